// ----- hw/rtl/tssr_pkg.sv -----
// package for the time slotted statistic ring: constants, types and op codes
`timescale 1ns / 1ps
`default_nettype none
package tssr_pkg;

  localparam int MaxSlotsDef = 64;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_PUSHG = 3'd1,
    OP_GET   = 3'd2,
    OP_DELTA = 3'd3,
    OP_WMAX  = 3'd4,
    OP_RMAX  = 3'd5,
    OP_BAD6  = 3'd6,
    OP_BAD7  = 3'd7
  } op_t;

  localparam logic [1:0] REG_SLOTS   = 2'd0;
  localparam logic [1:0] REG_FILLDEF = 2'd1;
  localparam logic [1:0] REG_DEFVAL  = 2'd2;
  localparam logic [1:0] REG_START   = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FRD,
    ST_FWAIT,
    ST_FILL,
    ST_CRD,
    ST_CWAIT,
    ST_OP,
    ST_DRD,
    ST_DWAIT,
    ST_SCAN,
    ST_SWAIT,
    ST_EMIT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture input transaction
    logic clr_init;    // start clearing sweep
    logic clr_step;    // write zero at sweep index and advance
    logic rd_cur;      // read slot of stored time
    logic fill_init;   // latch fill value and count
    logic fill_step;   // write fill into next slot
    logic fill_done;   // stored time takes now
    logic do_write;    // push or push if greater
    logic rd_back;     // read look-back slot for delta
    logic sub_back;    // subtract look-back slot from current value
    logic scan_init;   // start maxima walk
    logic scan_rd;     // read slot of walk index
    logic scan_acc;    // fold read data into best
    logic set_res;     // result register loads op result
    logic set_last;    // value of last flag for emitted result
    logic out_load;    // make output valid
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic time_same;
    logic fill_last;
    logic scan_last;
    logic win_zero;
    logic out_busy;
    logic mod_busy;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tssr_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tssr_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem_r [Depth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tssr_ctrl.sv -----
// controller state machine of the statistic ring
`timescale 1ns / 1ps
`default_nettype none
module tssr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     in_op,
  input  wire logic           cfg_clear,
  input  wire logic [2:0]     op_q,
  input  wire tssr_pkg::sts_t sts,
  output tssr_pkg::ctl_t      ctl
);
  import tssr_pkg::*;

  state_t state_r, state_nxt;
  op_t    opq;
  assign opq = op_t'(op_q);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cfg_clear) state_nxt = ST_CLEAR;
        else if (in_valid && !sts.mod_busy && in_op <= 3'(OP_RMAX)) state_nxt = ST_FRD;
      end
      ST_FRD:  state_nxt = sts.time_same ? ST_CRD : ST_FWAIT;
      ST_FWAIT: state_nxt = ST_FILL;
      ST_FILL: if (sts.fill_last) state_nxt = ST_CRD;
      ST_CRD:  state_nxt = sts.mod_busy ? ST_CRD : ST_CWAIT;
      ST_CWAIT: state_nxt = ST_OP;
      ST_OP: begin
        unique case (opq)
          OP_PUSH, OP_PUSHG: state_nxt = ST_IDLE;
          OP_GET:   state_nxt = ST_OUT;
          OP_DELTA: state_nxt = ST_DRD;
          OP_WMAX, OP_RMAX: state_nxt = sts.win_zero ?
              (opq == OP_WMAX ? ST_OUT : ST_IDLE) : ST_SCAN;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DRD:  state_nxt = ST_DWAIT;
      ST_DWAIT: state_nxt = ST_OUT;
      ST_SCAN: state_nxt = ST_SWAIT;
      ST_SWAIT: state_nxt = (opq == OP_RMAX) ? ST_EMIT : (sts.scan_last ? ST_OUT : ST_SCAN);
      ST_EMIT: if (!sts.out_busy) state_nxt = sts.scan_last ? ST_IDLE : ST_SCAN;
      ST_OUT:  if (!sts.out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = !cfg_clear && !sts.mod_busy;
        ctl.load_item = in_valid && !cfg_clear && !sts.mod_busy;
        ctl.clr_init = cfg_clear;
      end
      ST_FRD:  begin ctl.rd_cur = 1'b1; ctl.fill_done = sts.time_same; end
      ST_FWAIT: ctl.fill_init = 1'b1;
      ST_FILL: begin ctl.fill_step = 1'b1; ctl.fill_done = sts.fill_last; end
      ST_CRD:  ctl.rd_cur = 1'b1;
      ST_CWAIT: ;
      ST_OP: begin
        ctl.do_write = (opq == OP_PUSH) || (opq == OP_PUSHG);
        ctl.set_res = 1'b1;
        ctl.scan_init = 1'b1;
      end
      ST_DRD:  ctl.rd_back = 1'b1;
      ST_DWAIT: ctl.sub_back = 1'b1;
      ST_SCAN: ctl.scan_rd = 1'b1;
      ST_SWAIT: ctl.scan_acc = 1'b1;
      ST_EMIT: begin
        ctl.out_load = !sts.out_busy;
        ctl.set_last = sts.scan_last;
      end
      ST_OUT: begin
        ctl.out_load = !sts.out_busy;
        ctl.set_last = 1'b1;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/tssr_dp.sv -----
// datapath of the statistic ring: registers, slot ram, address and max logic
`timescale 1ns / 1ps
`default_nettype none
module tssr_dp #(
  parameter int MaxSlots = tssr_pkg::MaxSlotsDef
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_idx,
  input  wire logic [63:0]    cfg_data,
  input  wire logic [2:0]     in_op,
  input  wire logic [31:0]    in_now,
  input  wire logic [63:0]    in_sample,
  input  wire logic [6:0]     in_window,
  output logic [63:0]         out_result_value,
  output logic                out_last_of_run,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          op_q,
  input  wire tssr_pkg::ctl_t ctl,
  output tssr_pkg::sts_t      sts
);
  import tssr_pkg::*;

  localparam int AW = $clog2(MaxSlots);
  localparam int SW = $clog2(MaxSlots + 1);

  logic [SW-1:0] slots_r;
  logic          filldef_r;
  logic [63:0]   defval_r;
  logic [31:0]   start_r;
  logic [31:0]   stime_r;
  logic [31:0]   now_r;
  logic [63:0]   sample_r;
  logic [SW-1:0] win_r;
  logic [2:0]    op_r;
  logic [AW-1:0] cur_r;     // slot of stored time, stepped on short jumps, else reduced
  logic [AW-1:0] ptr_r;     // walk pointer
  logic [SW-1:0] cnt_r;     // steps remaining
  logic [31:0]   tw_r;      // time of the walk pointer during a fill
  logic [31:0]   mod_t_r;   // time bits still to reduce
  logic [AW-1:0] mod_r;     // partial remainder
  logic [5:0]    mod_cnt_r;
  logic          mod_busy_r;
  logic [63:0]   fill_r, best_r, curv_r, res_r, outv_r;
  logic          last_r, ov_r;
  logic [AW-1:0] addr;
  logic          we;
  logic [63:0]   wdata, rdata;
  logic [SW-1:0] wsel, sw_clamp, slots_nxt;
  logic [31:0]   start_nxt;
  logic [31:0]   tgap;
  logic          gap_short;
  logic [AW-1:0] nxt_ptr, prv_ptr, back_ptr;
  logic [SW:0]   back_sum;
  logic [AW:0]   mod_sh, mod_red;

  assign op_q = op_r;
  assign out_result_value = outv_r;
  assign out_last_of_run = last_r;
  assign out_valid = ov_r;

  // slot count clamp for a configuration write
  always_comb begin
    if (cfg_data[6:0] < 7'd2) sw_clamp = SW'(2);
    else if (cfg_data[6:0] > 7'(MaxSlots)) sw_clamp = SW'(MaxSlots);
    else sw_clamp = SW'(cfg_data[6:0]);
  end

  // register values as they stand after this edge's write
  assign slots_nxt = (cfg_we && cfg_idx == REG_SLOTS) ? sw_clamp : slots_r;
  assign start_nxt = (cfg_we && cfg_idx == REG_START) ? cfg_data[31:0] : start_r;

  // window clamp
  assign wsel = (SW'(in_window) > slots_r || in_window > 7'(MaxSlots)) ? slots_r
                : SW'(in_window);

  assign tgap = now_r - stime_r;
  assign gap_short = (tgap < 32'(slots_r));
  assign nxt_ptr = (SW'(ptr_r) + SW'(1) == slots_r) ? '0 : ptr_r + AW'(1);
  assign prv_ptr = (ptr_r == '0) ? AW'(slots_r - SW'(1)) : ptr_r - AW'(1);
  assign back_sum = (SW+1)'(cur_r) + (SW+1)'(slots_r) - (SW+1)'(win_r);
  assign back_ptr = (back_sum >= (SW+1)'(slots_r)) ? AW'(back_sum - (SW+1)'(slots_r))
                    : AW'(back_sum);

  // one restoring step of the time to slot reduction
  assign mod_sh  = {mod_r, mod_t_r[31]};
  assign mod_red = (mod_sh >= (AW+1)'(slots_r)) ? mod_sh - (AW+1)'(slots_r) : mod_sh;

  assign sts.clr_last  = (cnt_r == SW'(1));
  assign sts.time_same = (now_r == stime_r);
  assign sts.fill_last = (cnt_r == SW'(1));
  assign sts.scan_last = (cnt_r == SW'(1));
  assign sts.win_zero  = (win_r == '0);
  assign sts.out_busy  = ov_r && !out_ready;
  assign sts.mod_busy  = mod_busy_r;

  // ram port steering
  always_comb begin
    addr = cur_r;
    we = 1'b0;
    wdata = sample_r;
    priority if (ctl.clr_step) begin
      addr = ptr_r; we = 1'b1; wdata = '0;
    end else if (ctl.fill_step) begin
      addr = ptr_r; we = 1'b1; wdata = fill_r;
    end else if (ctl.do_write) begin
      addr = cur_r;
      we = (op_r == 3'(OP_PUSH)) || (sample_r > rdata);
    end else if (ctl.rd_back) begin
      addr = back_ptr;
    end else if (ctl.scan_rd) begin
      addr = ptr_r;
    end
  end

  tssr_ram #(.Width(64), .Depth(MaxSlots)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // configuration and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SW'(MaxSlots);
      filldef_r <= 1'b0;
      defval_r <= '0;
      start_r <= '0;
      stime_r <= '0;
      cur_r <= '0;
      ptr_r <= '0;
      cnt_r <= SW'(MaxSlots);
      tw_r <= '0;
      mod_t_r <= '0;
      mod_r <= '0;
      mod_cnt_r <= '0;
      mod_busy_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SLOTS:   slots_r <= sw_clamp;
          REG_FILLDEF: filldef_r <= cfg_data[0];
          REG_DEFVAL:  defval_r <= cfg_data;
          REG_START:   start_r <= cfg_data[31:0];
          default: ;
        endcase
      end
      // slot of a full time, one time bit per cycle
      if (mod_busy_r) begin
        mod_r <= mod_red[AW-1:0];
        mod_t_r <= {mod_t_r[30:0], 1'b0};
        mod_cnt_r <= mod_cnt_r - 6'd1;
        if (mod_cnt_r == 6'd1) begin
          mod_busy_r <= 1'b0;
          cur_r <= mod_red[AW-1:0];
        end
      end
      if (ctl.clr_init) begin
        stime_r <= start_nxt;
        ptr_r <= '0;
        cnt_r <= slots_nxt;
        mod_t_r <= start_nxt;
        mod_r <= '0;
        mod_cnt_r <= 6'd32;
        mod_busy_r <= 1'b1;
      end
      if (ctl.clr_step) begin
        ptr_r <= ptr_r + AW'(1);
        cnt_r <= cnt_r - SW'(1);
      end
      if (ctl.fill_init) begin
        fill_r <= filldef_r ? defval_r : rdata;
        ptr_r <= (stime_r == '1) ? '0 :
                 ((SW'(cur_r) + SW'(1) == slots_r) ? '0 : cur_r + AW'(1));
        tw_r <= stime_r + 32'd1;
        cnt_r <= gap_short ? SW'(tgap) : slots_r;
        // long or backward jump: slot of now comes from the full time
        if (!gap_short) begin
          mod_t_r <= now_r;
          mod_r <= '0;
          mod_cnt_r <= 6'd32;
          mod_busy_r <= 1'b1;
        end
      end
      if (ctl.fill_step) begin
        // time wrapping to zero maps to slot zero
        ptr_r <= (tw_r == '1) ? '0 : nxt_ptr;
        tw_r <= tw_r + 32'd1;
        cnt_r <= cnt_r - SW'(1);
      end
      if (ctl.fill_done) begin
        stime_r <= now_r;
        // short jump ends on the slot of now
        if (ctl.fill_step && gap_short) begin
          cur_r <= ptr_r;
        end
      end
      if (ctl.scan_init) begin
        ptr_r <= cur_r;
        cnt_r <= win_r;
      end
      if (ctl.scan_acc && op_r != 3'(OP_RMAX)) begin
        ptr_r <= prv_ptr;
        cnt_r <= cnt_r - SW'(1);
      end
      if (ctl.out_load && op_r == 3'(OP_RMAX) && !ctl.set_last) begin
        ptr_r <= prv_ptr;
        cnt_r <= cnt_r - SW'(1);
      end
      if (ctl.out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      op_r <= in_op;
      now_r <= in_now;
      sample_r <= in_sample;
      win_r <= wsel;
    end
    if (ctl.set_res) begin
      curv_r <= rdata;
      best_r <= '0;
      res_r <= (op_r == 3'(OP_GET)) ? rdata : '0;
    end
    // delta subtract on the wait cycle after the look-back read
    if (ctl.sub_back) res_r <= curv_r - rdata;
    if (ctl.scan_acc) begin
      if (rdata > best_r) begin
        best_r <= rdata;
        res_r <= rdata;
      end else begin
        res_r <= best_r;
      end
    end
    // output register holds the transaction until accepted
    if (ctl.out_load) begin
      outv_r <= res_r;
      last_r <= ctl.set_last;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/time_slotted_stat_ring.sv -----
// top level of the time slotted statistic ring
// The block keeps one 64-bit statistic per time slot in a ring of up to
// MaxSlots entries held in a single-port RAM. Input transactions carry op,
// now, sample and window on a valid/ready channel; results leave on a
// valid/ready channel with result_value and last_of_run.
// One transaction at a time: a new one is accepted only in idle. With no
// time change a push or get reads the slot of the stored time, then a push
// writes it and a get loads the output register. A time change first fills
// the skipped slots, up to the slot count; a jump of the slot count or more,
// or backwards, also waits for the reduction of the time to its slot. Window
// max and running maxima walk back from the current slot over the window.
// Push ops give no result; get, delta and window max give one; running
// maxima gives window results, the last one flagged.
// After reset a clearing sweep zeroes all MaxSlots entries of the RAM; after
// a write of the slot count or start time the sweep and the slot reduction
// keep the input blocked until both are done. A stalled receiver holds the
// output register and the walk waits. The user writes configuration through
// cfg_we, cfg_index and cfg_data only while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
module time_slotted_stat_ring #(
  parameter int MaxSlots = tssr_pkg::MaxSlotsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_now,
  input  wire logic [63:0] in_sample,
  input  wire logic [6:0]  in_window,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_value,
  output logic             out_last_of_run
);
  import tssr_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic [2:0] op_q;
  logic cfg_clear;

  assign cfg_clear = cfg_we && (cfg_index == REG_SLOTS || cfg_index == REG_START);

  tssr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .cfg_clear(cfg_clear), .op_q(op_q), .sts(sts), .ctl(ctl)
  );

  tssr_dp #(.MaxSlots(MaxSlots)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .in_op(in_op), .in_now(in_now), .in_sample(in_sample),
    .in_window(in_window), .out_result_value(out_result_value),
    .out_last_of_run(out_last_of_run), .out_valid(out_valid),
    .out_ready(out_ready), .op_q(op_q), .ctl(ctl), .sts(sts)
  );
endmodule
`default_nettype wire
